### hw/rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants, codes and helper functions for the device roster matcher.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int ROSTER_SLOTS = 32;  // 1..32
  localparam int SLOT_W = (ROSTER_SLOTS > 1) ? $clog2(ROSTER_SLOTS) : 1;
  localparam int CNT_W = $clog2(ROSTER_SLOTS + 1);

  localparam int ID_W      = 64;
  localparam int MASK_W    = 32;
  localparam int TOT_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int SLOTP_W   = 5;
  localparam int BYTES     = 8;
  localparam int CRC_BYTES = 7;
  localparam int CRC_POS   = 56;

  localparam logic [7:0]       CRC_POLY = 8'h8C;
  localparam logic [TOT_W-1:0] TOT_MAX  = {TOT_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_BEGIN  = 2'd1,
    ACT_DETECT = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACK     = 3'd0,
    ST_CRC_BAD = 3'd1,
    ST_MATCHED = 3'd2,
    ST_ADDED   = 3'd3,
    ST_FULL    = 3'd4,
    ST_SUMMARY = 3'd5
  } status_t;

  // CRC unit status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic ok;
  } crc_stat_t;

  // One byte of the reflected Dallas CRC-8, LSB first.
  function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc_in;
    d = data;
    for (int b = 0; b < 8; b++) begin
      mix = c[0] ^ d[0];
      c   = c >> 1;
      if (mix) c = c ^ CRC_POLY;
      d   = d >> 1;
    end
    return c;
  endfunction

  // Byte k moves to byte 7-k.
  function automatic logic [ID_W-1:0] byte_swap(logic [ID_W-1:0] v);
    logic [ID_W-1:0] r;
    r = '0;
    for (int k = 0; k < BYTES; k++) begin
      r[8*(BYTES-1-k) +: 8] = v[8*k +: 8];
    end
    return r;
  endfunction

endpackage

### hw/rtl/brs_ram.sv
// ----------------------------------------------------------------------------
// brs_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module brs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### hw/rtl/brs_crc8.sv
// ----------------------------------------------------------------------------
// brs_crc8
// Byte-serial Dallas CRC-8 checker: one byte per cycle over the low seven
// bytes, compared with the top byte.
// ----------------------------------------------------------------------------
module brs_crc8
  import brs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [ID_W-1:0] id_value,
  output crc_stat_t       stat
);

  logic [CRC_POS-1:0] data;
  logic [7:0]         chk;
  logic [7:0]         crc;
  logic [2:0]         cnt;
  logic               busy;
  logic               done;
  logic               ok;
  logic [7:0]         crc_next;

  assign crc_next = crc8_byte(crc, data[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ok   <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        data <= id_value[CRC_POS-1:0];
        chk  <= id_value[ID_W-1:CRC_POS];
        crc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        crc  <= crc_next;
        data <= data >> 8;
        cnt  <= cnt + 3'd1;
        if (cnt == 3'(CRC_BYTES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          ok   <= (crc_next == chk);
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done, ok: ok};

endmodule

### hw/rtl/bus_device_roster_matcher_top.sv
// ----------------------------------------------------------------------------
// bus_device_roster_matcher_top
// Device roster matcher: roster of 64-bit IDs in a RAM, CRC check of detected
// IDs, sequential match / insert walk over the slots, scan summary.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake           Payload
//  -------  ------------------  ------------------------------------------
//  in       in_valid/in_ready   action, slot_index, id_value
//  out      out_valid/out_ready status, slot_hit, found_mask, added_mask,
//                               count_found, count_expected, count_added,
//                               count_missing
//
//  Transaction steps: a load writes the roster and answers; begin / end scan
//  count the occupancy flags over all slots; a detected ID runs the CRC byte
//  steps and the CRC verdict is taken, then a bad-CRC ID answers, while a good
//  one walks the roster one slot per cycle through the registered RAM read
//  port, stopping at the first match, and the result follows.
//  One transaction at a time: in_ready is high only while the sequencer idles.
//  Results sit in an output register, so a new transaction is taken while
//  the last result still waits for out_ready; the sequencer stalls only when
//  a second result is ready before the first one has left.
//  Reset clears masks, counters and per-slot occupancy flags at once; a slot
//  whose flag is clear reads as empty, so the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module bus_device_roster_matcher_top
  import brs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [SLOTP_W-1:0] slot_index,
  input  logic [ID_W-1:0]    id_value,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOTP_W-1:0] slot_hit,
  output logic [MASK_W-1:0]  found_mask,
  output logic [MASK_W-1:0]  added_mask,
  output logic [TOT_W-1:0]   count_found,
  output logic [TOT_W-1:0]   count_expected,
  output logic [TOT_W-1:0]   count_added,
  output logic [TOT_W-1:0]   count_missing
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_SCAN,
    S_COUNT,
    S_EMIT
  } state_t;

  state_t state;
  action_t act;

  // scan state
  logic [ROSTER_SLOTS-1:0] occ;        // slot holds a nonzero ID
  logic [ROSTER_SLOTS-1:0] seen_bits;
  logic [ROSTER_SLOTS-1:0] new_bits;
  logic [TOT_W-1:0]        expected_total;
  logic [TOT_W-1:0]        seen_total;
  logic [TOT_W-1:0]        new_total;

  // transaction working registers
  logic [ID_W-1:0]         id_reg;
  logic [ID_W-1:0]         rev;
  logic [CNT_W-1:0]        rd_idx;
  logic                    cmp_vld;
  logic [SLOT_W-1:0]       cmp_idx;
  logic                    empty_fnd;
  logic [SLOT_W-1:0]       empty_idx;
  logic [ROSTER_SLOTS-1:0] cnt_mask;
  logic [CNT_W-1:0]        cnt_left;
  logic [TOT_W-1:0]        cnt_acc;
  logic [TOT_W-1:0]        cnt_sum;

  // pending result
  status_t                 res_status;
  logic [SLOT_W-1:0]       res_slot;
  logic [TOT_W-1:0]        res_missing;

  // RAM port
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [ID_W-1:0]         ram_wdata;
  logic                    ram_re;
  logic [SLOT_W-1:0]       ram_raddr;
  logic [ID_W-1:0]         ram_rdata;

  crc_stat_t               crc_stat;

  logic                    accept;
  logic                    load_ok;
  logic [SLOT_W-1:0]       load_idx;
  logic [ID_W-1:0]         slot_val;
  logic                    hit;
  logic                    empty_now;
  logic                    last;
  logic                    ins_vld;
  logic [SLOT_W-1:0]       ins_idx;
  logic                    scan_add;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  // loads beyond the roster are acked but write nothing
  assign load_ok  = ({1'b0, slot_index} < (SLOTP_W + 1)'(ROSTER_SLOTS));
  assign load_idx = slot_index[SLOT_W-1:0];

  assign rev = byte_swap(id_reg);

  // compare stage: data read last cycle for slot cmp_idx
  assign slot_val  = occ[cmp_idx] ? ram_rdata : '0;
  assign hit       = cmp_vld && (slot_val == rev);
  assign empty_now = cmp_vld && (slot_val == '0);
  assign last      = cmp_vld && (cmp_idx == SLOT_W'(ROSTER_SLOTS - 1));
  assign ins_vld   = empty_fnd || empty_now;
  assign ins_idx   = empty_fnd ? empty_idx : cmp_idx;
  assign scan_add  = (state == S_SCAN) && last && !hit && ins_vld;

  assign cnt_sum = cnt_acc + TOT_W'(cnt_mask[0]);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_idx;
    ram_wdata = id_value;
    ram_re    = 1'b0;
    ram_raddr = rd_idx[SLOT_W-1:0];
    if (accept && (action == ACT_LOAD) && load_ok) begin
      ram_we = 1'b1;
    end else if (scan_add) begin
      ram_we    = 1'b1;
      ram_waddr = ins_idx;
      ram_wdata = rev;
    end
    if (state == S_SCAN) begin
      ram_re = (rd_idx < CNT_W'(ROSTER_SLOTS));
    end
  end

  brs_ram #(
    .WIDTH (ID_W),
    .DEPTH (ROSTER_SLOTS)
  ) u_roster (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brs_crc8 u_crc (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && (action == ACT_DETECT)),
    .id_value (id_value),
    .stat     (crc_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      occ            <= '0;
      seen_bits      <= '0;
      new_bits       <= '0;
      expected_total <= '0;
      seen_total     <= '0;
      new_total      <= '0;
      cmp_vld        <= 1'b0;
      empty_fnd      <= 1'b0;
    end else begin
      // S_EMIT reloads the output register itself
      if (out_valid && out_ready && (state != S_EMIT)) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            id_reg      <= id_value;
            act         <= action_t'(action);
            res_slot    <= '0;
            res_missing <= '0;
            cnt_left    <= CNT_W'(ROSTER_SLOTS);
            cnt_acc     <= '0;
            case (action_t'(action))
              ACT_LOAD: begin
                if (load_ok) occ[load_idx] <= (id_value != '0);
                res_status <= ST_ACK;
                state      <= S_EMIT;
              end
              ACT_BEGIN: begin
                seen_bits  <= '0;
                new_bits   <= '0;
                seen_total <= '0;
                new_total  <= '0;
                cnt_mask   <= occ;
                state      <= S_COUNT;
              end
              ACT_DETECT: begin
                state <= S_CRC;
              end
              ACT_END: begin
                cnt_mask <= occ & ~(seen_bits | new_bits);
                state    <= S_COUNT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_COUNT: begin
          cnt_acc  <= cnt_sum;
          cnt_mask <= cnt_mask >> 1;
          cnt_left <= cnt_left - CNT_W'(1);
          if (cnt_left == CNT_W'(1)) begin
            if (act == ACT_BEGIN) begin
              expected_total <= cnt_sum;
              res_status     <= ST_ACK;
            end else begin
              res_missing <= cnt_sum;
              res_status  <= ST_SUMMARY;
            end
            state <= S_EMIT;
          end
        end

        S_CRC: begin
          if (crc_stat.done) begin
            if (crc_stat.ok) begin
              if (seen_total != TOT_MAX) seen_total <= seen_total + TOT_W'(1);
              rd_idx    <= '0;
              cmp_vld   <= 1'b0;
              empty_fnd <= 1'b0;
              state     <= S_SCAN;
            end else begin
              res_status <= ST_CRC_BAD;
              state      <= S_EMIT;
            end
          end
        end

        S_SCAN: begin
          rd_idx  <= rd_idx + CNT_W'(ram_re);
          cmp_vld <= ram_re;
          cmp_idx <= ram_raddr;
          if (empty_now && !empty_fnd) begin
            empty_fnd <= 1'b1;
            empty_idx <= cmp_idx;
          end
          if (hit) begin
            // first slot equal to the reversed ID, an empty one for a zero ID
            seen_bits[cmp_idx] <= 1'b1;
            res_status         <= ST_MATCHED;
            res_slot           <= cmp_idx;
            state              <= S_EMIT;
          end else if (last) begin
            if (ins_vld) begin
              occ[ins_idx]      <= 1'b1;
              new_bits[ins_idx] <= 1'b1;
              if (new_total != TOT_MAX) new_total <= new_total + TOT_W'(1);
              res_status        <= ST_ADDED;
              res_slot          <= ins_idx;
            end else begin
              res_status <= ST_FULL;
            end
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            slot_hit  <= SLOTP_W'(res_slot);
            if (res_status == ST_SUMMARY) begin
              found_mask     <= MASK_W'(seen_bits);
              added_mask     <= MASK_W'(new_bits);
              count_found    <= seen_total;
              count_expected <= expected_total;
              count_added    <= new_total;
              count_missing  <= res_missing;
            end else begin
              found_mask     <= '0;
              added_mask     <= '0;
              count_found    <= '0;
              count_expected <= '0;
              count_added    <= '0;
              count_missing  <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // one transaction in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transaction accepted while another is in flight");

  // an insert only ever lands on an empty slot and never stores zero
  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    scan_add |-> (!occ[ins_idx] && (rev != '0)))
    else $error("insert into occupied slot or of a zero ID");

  a_expected_bound: assert property (@(posedge clk) disable iff (rst)
    expected_total <= TOT_W'(ROSTER_SLOTS))
    else $error("expected count above roster size");

  // only summaries carry masks and counts
  a_summary_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_SUMMARY)) |->
      ((found_mask == '0) && (added_mask == '0) && (count_missing == '0)))
    else $error("summary fields set on a non-summary result");

  a_crc_owner: assert property (@(posedge clk) disable iff (rst)
    crc_stat.done |-> (state == S_CRC))
    else $error("CRC completion outside the CRC phase");

endmodule
